>>> hw/rtl/duty_command_pwm_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the duty command PWM controller
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DUTY_COMMAND_PWM_CONTROLLER_CORE_ASSERT_SVH
`define DUTY_COMMAND_PWM_CONTROLLER_CORE_ASSERT_SVH

// Check on every clock edge while reset is low.
`define DCPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define DCPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dcpc_pkg.sv
// ----------------------------------------------------------------------------
// Duty command PWM controller package
// Shared types, register map, drive mode codes and fixed constants.
// ----------------------------------------------------------------------------
package dcpc_pkg;

  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int CHAR_W  = 8;
  localparam int DUTY_W  = 7;
  localparam int VALUE_W = 24;
  localparam int PROD_W  = 31;

  // Register word index, taken from paddr[2]
  localparam logic REG_TERM   = 1'b0;
  localparam logic REG_RELOAD = 1'b1;

  localparam logic [CHAR_W-1:0]  TERM_RESET   = 8'd110;
  localparam logic [VALUE_W-1:0] RELOAD_RESET = 24'd40000;
  localparam logic [DUTY_W-1:0]  DUTY_RESET   = 7'd50;
  localparam logic [VALUE_W-1:0] STEP_RESET   = 24'd10;
  localparam logic [DUTY_W-1:0]  PCT_MAX      = 7'd100;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = 24'hFFFFFF;

  localparam logic [CHAR_W-1:0] CHAR_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for all p below 2^31
  localparam logic [PROD_W-1:0] RECIP_100   = 31'd1374389535;
  localparam int                RECIP_SHIFT = 37;

  typedef logic [1:0] drive_mode_t;
  localparam drive_mode_t MODE_LOW  = 2'd0;
  localparam drive_mode_t MODE_HIGH = 2'd1;
  localparam drive_mode_t MODE_PWM  = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } parse_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  term;
    logic [VALUE_W-1:0] reload;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [VALUE_W-1:0] step;
    logic               changed;
    logic               report;
  } cmd_result_t;

endpackage

>>> hw/rtl/dcpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the terminator character and period reload.
// ----------------------------------------------------------------------------
module dcpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [dcpc_pkg::DATA_W-1:0]   pwdata,
  output logic [dcpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dcpc_pkg::cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.term   <= dcpc_pkg::TERM_RESET;
      cfg.reload <= dcpc_pkg::RELOAD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        dcpc_pkg::REG_TERM:   cfg.term   <= pwdata[dcpc_pkg::CHAR_W-1:0];
        dcpc_pkg::REG_RELOAD: cfg.reload <= pwdata[dcpc_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dcpc_pkg::REG_TERM:   prdata = {24'd0, cfg.term};
      dcpc_pkg::REG_RELOAD: prdata = {8'd0, cfg.reload};
      default:              prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/dcpc_cmd_engine.sv
// ----------------------------------------------------------------------------
// Command engine
// Input register, command parser, duty and step state, and button handling.
// ----------------------------------------------------------------------------
module dcpc_cmd_engine #(
  parameter int BUFFER_LEN = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dcpc_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  logic                        op,
  input  logic [dcpc_pkg::CHAR_W-1:0] char_code,
  input  logic                        up_pressed,
  input  logic                        down_pressed,
  output logic                        cmd_res_valid,
  input  logic                        cmd_res_ready,
  output dcpc_pkg::cmd_result_t       cmd_res
);

  localparam int                CNT_W    = $clog2(BUFFER_LEN);
  localparam logic [CNT_W-1:0]  KEEP_MAX = CNT_W'(BUFFER_LEN - 1);

  // Input register
  logic                        v1;
  logic                        s_op;
  logic [dcpc_pkg::CHAR_W-1:0] s_char;
  logic                        s_up;
  logic                        s_down;

  // Command state
  logic [CNT_W-1:0]             char_count,      char_count_next;
  logic                         is_step_command, is_step_command_next;
  dcpc_pkg::parse_phase_t       parse_phase,     parse_phase_next;
  logic                         number_negative, number_negative_next;
  logic [dcpc_pkg::VALUE_W-1:0] number_value,    number_value_next;
  logic [dcpc_pkg::DUTY_W-1:0]  duty_level,      duty_level_next;
  logic [dcpc_pkg::VALUE_W-1:0] step_level,      step_level_next;
  logic                         changed, report;

  logic s2_free, s1_free, advance;

  logic       is_digit, is_space, is_sign;
  logic [27:0] acc;
  logic [24:0] up_sum;
  logic [dcpc_pkg::DUTY_W-1:0] duty_up;

  assign s2_free   = !cmd_res_valid || cmd_res_ready;
  assign s1_free   = !v1 || s2_free;
  assign cmd_stall = !s1_free;
  assign advance   = v1 && s2_free;

  assign is_digit = s_char inside {[8'h30:8'h39]};
  assign is_space = (s_char == dcpc_pkg::CHAR_SPACE) || (s_char inside {[8'h09:8'h0D]});
  assign is_sign  = (s_char == dcpc_pkg::CHAR_PLUS) || (s_char == dcpc_pkg::CHAR_MINUS);
  assign acc      = {1'b0, number_value, 3'b000} + {3'b000, number_value, 1'b0}
                  + {24'd0, s_char[3:0]};

  assign up_sum  = {18'd0, duty_level} + {1'b0, step_level};
  assign duty_up = !s_up ? duty_level :
                   (up_sum > {18'd0, dcpc_pkg::PCT_MAX}) ? dcpc_pkg::PCT_MAX :
                   up_sum[dcpc_pkg::DUTY_W-1:0];

  always_comb begin
    char_count_next      = char_count;
    is_step_command_next = is_step_command;
    parse_phase_next     = parse_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    duty_level_next      = duty_level;
    step_level_next      = step_level;
    changed              = 1'b0;
    report               = 1'b0;

    if (s_op) begin
      duty_level_next = duty_up;
      if (s_down) begin
        duty_level_next = (step_level >= {17'd0, duty_up}) ? '0 :
                          duty_up - step_level[dcpc_pkg::DUTY_W-1:0];
      end
      changed = s_up | s_down;
      report  = s_up | s_down;
    end else if (s_char == cfg.term) begin
      if (char_count != '0) begin
        if (is_step_command) begin
          step_level_next = (number_negative || number_value == '0) ?
                            24'd1 : number_value;
        end else if (number_negative) begin
          duty_level_next = '0;
        end else begin
          duty_level_next = (number_value > {17'd0, dcpc_pkg::PCT_MAX}) ?
                            dcpc_pkg::PCT_MAX : number_value[dcpc_pkg::DUTY_W-1:0];
        end
        changed = 1'b1;
      end
      // restart the parser
      char_count_next      = '0;
      is_step_command_next = 1'b0;
      parse_phase_next     = dcpc_pkg::PH_SKIP;
      number_negative_next = 1'b0;
      number_value_next    = '0;
    end else if (char_count < KEEP_MAX) begin
      char_count_next = char_count + CNT_W'(1);
      if (char_count == '0 && s_char == dcpc_pkg::CHAR_S) begin
        is_step_command_next = 1'b1;
      end else begin
        case (parse_phase)
          dcpc_pkg::PH_SKIP: begin
            if (is_sign) begin
              number_negative_next = (s_char == dcpc_pkg::CHAR_MINUS);
              parse_phase_next     = dcpc_pkg::PH_NUM;
            end else if (is_digit) begin
              parse_phase_next  = dcpc_pkg::PH_NUM;
              number_value_next = (acc > {4'd0, dcpc_pkg::VALUE_MAX}) ?
                                  dcpc_pkg::VALUE_MAX : acc[23:0];
            end else if (!is_space) begin
              parse_phase_next = dcpc_pkg::PH_DONE;
            end
          end
          dcpc_pkg::PH_NUM: begin
            if (is_digit) begin
              number_value_next = (acc > {4'd0, dcpc_pkg::VALUE_MAX}) ?
                                  dcpc_pkg::VALUE_MAX : acc[23:0];
            end else begin
              parse_phase_next = dcpc_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1              <= 1'b0;
      cmd_res_valid   <= 1'b0;
      char_count      <= '0;
      is_step_command <= 1'b0;
      parse_phase     <= dcpc_pkg::PH_SKIP;
      number_negative <= 1'b0;
      number_value    <= '0;
      duty_level      <= dcpc_pkg::DUTY_RESET;
      step_level      <= dcpc_pkg::STEP_RESET;
    end else begin
      if (s1_free) begin
        v1 <= cmd_valid;
      end
      if (s2_free) begin
        cmd_res_valid <= v1;
      end
      if (advance) begin
        char_count      <= char_count_next;
        is_step_command <= is_step_command_next;
        parse_phase     <= parse_phase_next;
        number_negative <= number_negative_next;
        number_value    <= number_value_next;
        duty_level      <= duty_level_next;
        step_level      <= step_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s_op   <= op;
      s_char <= char_code;
      s_up   <= up_pressed;
      s_down <= down_pressed;
    end
    if (advance) begin
      cmd_res.duty    <= duty_level_next;
      cmd_res.step    <= step_level_next;
      cmd_res.changed <= changed;
      cmd_res.report  <= report;
    end
  end

endmodule

>>> hw/rtl/dcpc_match_unit.sv
// ----------------------------------------------------------------------------
// Match unit
// Drive mode decode and timer match, reload*(100-duty)/100, over two stages.
// ----------------------------------------------------------------------------
module dcpc_match_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dcpc_pkg::VALUE_W-1:0] reload,
  input  logic                         cmd_res_valid,
  output logic                         cmd_res_ready,
  input  dcpc_pkg::cmd_result_t        cmd_res,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [dcpc_pkg::DUTY_W-1:0]  duty_percent,
  output logic [dcpc_pkg::VALUE_W-1:0] step_size,
  output dcpc_pkg::drive_mode_t        drive_mode,
  output logic [dcpc_pkg::VALUE_W-1:0] match_value,
  output logic                         settings_changed,
  output logic                         report_duty
);

  localparam int QW = 2 * dcpc_pkg::PROD_W;

  logic                        v3;
  dcpc_pkg::cmd_result_t       s3_res;
  dcpc_pkg::drive_mode_t       s3_mode;
  logic [dcpc_pkg::PROD_W-1:0] s3_prod;

  dcpc_pkg::drive_mode_t       mode;
  logic [dcpc_pkg::DUTY_W-1:0] k;
  logic [dcpc_pkg::PROD_W-1:0] prod;
  logic [QW-1:0]               scaled;
  logic                        s4_free;

  assign s4_free       = !res_valid || !res_stall;
  assign cmd_res_ready = !v3 || s4_free;

  always_comb begin
    if (cmd_res.duty == '0) begin
      mode = dcpc_pkg::MODE_LOW;
    end else if (cmd_res.duty >= dcpc_pkg::PCT_MAX) begin
      mode = dcpc_pkg::MODE_HIGH;
    end else begin
      mode = dcpc_pkg::MODE_PWM;
    end
  end

  // forced modes get a zero factor, so the match drops to zero
  assign k      = (mode == dcpc_pkg::MODE_PWM) ? dcpc_pkg::PCT_MAX - cmd_res.duty : '0;
  assign prod   = {7'd0, reload} * {24'd0, k};
  assign scaled = {{dcpc_pkg::PROD_W{1'b0}}, s3_prod}
                * {{dcpc_pkg::PROD_W{1'b0}}, dcpc_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_res_ready) begin
        v3 <= cmd_res_valid;
      end
      if (s4_free) begin
        res_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_res_ready && cmd_res_valid) begin
      s3_res  <= cmd_res;
      s3_mode <= mode;
      s3_prod <= prod;
    end
    if (s4_free && v3) begin
      duty_percent     <= s3_res.duty;
      step_size        <= s3_res.step;
      drive_mode       <= s3_mode;
      match_value      <= scaled[dcpc_pkg::RECIP_SHIFT +: dcpc_pkg::VALUE_W];
      settings_changed <= s3_res.changed;
      report_duty      <= s3_res.report;
    end
  end

endmodule

>>> hw/rtl/duty_command_pwm_controller_core.sv
// ----------------------------------------------------------------------------
// Duty command PWM controller core
// Turns received command characters and button presses into PWM settings.
// ----------------------------------------------------------------------------
// Every accepted item (a character or a button event) returns one result item,
// and a new item may enter on every cycle while cmd_stall is low. The rate
// is set by the command engine, which updates the duty, step and parser
// state from one item before the next is taken. A result passes through the
// input register, that update, the reload by (100 - duty) product and the
// reciprocal scaling that divides it by 100. Stalls propagate back stage by
// stage, so empty stages still take items while a result waits. Commands end
// on the terminator register (reset 'n'); the reload register sets the timer
// period for match_value.
// ----------------------------------------------------------------------------
module duty_command_pwm_controller_core #(
  parameter int BUFFER_LEN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcpc_pkg::DATA_W-1:0]  pwdata,
  output logic [dcpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         op,
  input  logic [dcpc_pkg::CHAR_W-1:0]  char_code,
  input  logic                         up_pressed,
  input  logic                         down_pressed,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [dcpc_pkg::DUTY_W-1:0]  duty_percent,
  output logic [dcpc_pkg::VALUE_W-1:0] step_size,
  output logic [1:0]                   drive_mode,
  output logic [dcpc_pkg::VALUE_W-1:0] match_value,
  output logic                         settings_changed,
  output logic                         report_duty
);

  dcpc_pkg::cfg_t        cfg;
  logic                  cmd_res_valid;
  logic                  cmd_res_ready;
  dcpc_pkg::cmd_result_t cmd_res;

  dcpc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcpc_cmd_engine #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_cmd_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .op            (op),
    .char_code     (char_code),
    .up_pressed    (up_pressed),
    .down_pressed  (down_pressed),
    .cmd_res_valid (cmd_res_valid),
    .cmd_res_ready (cmd_res_ready),
    .cmd_res       (cmd_res)
  );

  dcpc_match_unit u_match_unit (
    .clk              (clk),
    .rst              (rst),
    .reload           (cfg.reload),
    .cmd_res_valid    (cmd_res_valid),
    .cmd_res_ready    (cmd_res_ready),
    .cmd_res          (cmd_res),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .duty_percent     (duty_percent),
    .step_size        (step_size),
    .drive_mode       (drive_mode),
    .match_value      (match_value),
    .settings_changed (settings_changed),
    .report_duty      (report_duty)
  );

endmodule

>>> hw/rtl/dcpc_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the controller core over time.
// ----------------------------------------------------------------------------
`include "duty_command_pwm_controller_core_assert.svh"

module dcpc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic [dcpc_pkg::DUTY_W-1:0]  duty_percent,
  input logic [dcpc_pkg::VALUE_W-1:0] step_size,
  input logic [1:0]                   drive_mode,
  input logic [dcpc_pkg::VALUE_W-1:0] match_value,
  input logic                         settings_changed,
  input logic                         report_duty
);

  `DCPC_ASSERT(a_res_hold,
    res_valid && res_stall |=> res_valid && $stable(duty_percent) && $stable(match_value),
    "result item changed while stalled")

  `DCPC_ASSERT(a_mode_duty,
    res_valid |->
      (drive_mode == dcpc_pkg::MODE_LOW && duty_percent == 7'd0 && match_value == 24'd0) ||
      (drive_mode == dcpc_pkg::MODE_HIGH && duty_percent == dcpc_pkg::PCT_MAX &&
       match_value == 24'd0) ||
      (drive_mode == dcpc_pkg::MODE_PWM && duty_percent != 7'd0 &&
       duty_percent < dcpc_pkg::PCT_MAX),
    "drive mode does not match duty")

  `DCPC_ASSERT(a_step_flags,
    res_valid |-> step_size != 24'd0 && (settings_changed || !report_duty),
    "zero step or report without change")

  `DCPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid straight after reset")

endmodule

bind duty_command_pwm_controller_core dcpc_checker u_dcpc_checker (.*);
